// ===== hdl/jtsl_pkg.sv =====
package jtsl_pkg;

  localparam logic [3:0] KIND_PUNCT = 4'd0;
  localparam logic [3:0] KIND_TRUE  = 4'd1;
  localparam logic [3:0] KIND_FALSE = 4'd2;
  localparam logic [3:0] KIND_NULL  = 4'd3;
  localparam logic [3:0] KIND_SCHAR = 4'd4;
  localparam logic [3:0] KIND_SEND  = 4'd5;
  localparam logic [3:0] KIND_NCHAR = 4'd6;
  localparam logic [3:0] KIND_NEND  = 4'd7;
  localparam logic [3:0] KIND_ERROR = 4'd8;
  localparam logic [3:0] KIND_END   = 4'd9;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNEXP   = 3'd1;
  localparam logic [2:0] ERR_DIGIT   = 3'd2;
  localparam logic [2:0] ERR_KEYWORD = 3'd3;
  localparam logic [2:0] ERR_EARLY   = 3'd4;
  localparam logic [2:0] ERR_QUOTE   = 3'd5;

  localparam int WORD_STORE = 5;
  localparam logic [2:0] WORD_LIMIT = 3'd7;

  localparam logic [39:0] WORD_TRUE  = 40'h0065757274;
  localparam logic [39:0] WORD_FALSE = 40'h65736C6166;
  localparam logic [39:0] WORD_NULL  = 40'h006C6C756E;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic [2:0] code;
  } result_t;

  // One accepted byte: one or two results.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b == 8'h7B) || (b == 8'h7D) || (b == 8'h5B) || (b == 8'h5D) ||
           (b == 8'h3A) || (b == 8'h2C);
  endfunction

endpackage

// ===== hdl/jtsl_front.sv =====
module jtsl_front import jtsl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       entry_valid,
  output entry_t     entry
);

  typedef enum logic [11:0] {
    M_IDLE  = 12'b000000000001,
    M_STR   = 12'b000000000010,
    M_ESC   = 12'b000000000100,
    M_MINUS = 12'b000000001000,
    M_INT   = 12'b000000010000,
    M_DOT   = 12'b000000100000,
    M_FRAC  = 12'b000001000000,
    M_E     = 12'b000010000000,
    M_ESIGN = 12'b000100000000,
    M_EXP   = 12'b001000000000,
    M_WORD  = 12'b010000000000,
    M_ERR   = 12'b100000000000
  } mode_t;

  mode_t       mode, mode_next;
  logic [39:0] kchars, kchars_next;
  logic [2:0]  kcount, kcount_next;

  logic        id_v, id_load;
  result_t     id_res;
  mode_t       id_mode;

  logic        kw_ok;
  logic [3:0]  kw_kind;

  logic        pre_v, main_v, use_idle;
  result_t     pre, main;
  logic [2:0]  kcount_inc;

  // Token start classification.
  always_comb begin
    id_v    = 1'b0;
    id_load = 1'b0;
    id_res  = '0;
    id_mode = M_IDLE;
    priority if (is_space(in_byte)) begin
      id_mode = M_IDLE;
    end else if (in_byte == 8'h22) begin
      id_mode = M_STR;
    end else if (is_punct(in_byte)) begin
      id_v   = 1'b1;
      id_res = '{kind: KIND_PUNCT, ch: in_byte, code: ERR_NONE};
    end else if (in_byte == 8'h2D) begin
      id_v    = 1'b1;
      id_res  = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
      id_mode = M_MINUS;
    end else if (is_digit(in_byte)) begin
      id_v    = 1'b1;
      id_res  = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
      id_mode = M_INT;
    end else if (is_alpha(in_byte)) begin
      id_load = 1'b1;
      id_mode = M_WORD;
    end else begin
      id_v    = 1'b1;
      id_res  = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_UNEXP};
      id_mode = M_ERR;
    end
  end

  always_comb begin
    kw_ok   = 1'b1;
    kw_kind = KIND_TRUE;
    priority if (kcount == 3'd4 && kchars == WORD_TRUE) begin
      kw_kind = KIND_TRUE;
    end else if (kcount == 3'd5 && kchars == WORD_FALSE) begin
      kw_kind = KIND_FALSE;
    end else if (kcount == 3'd4 && kchars == WORD_NULL) begin
      kw_kind = KIND_NULL;
    end else begin
      kw_ok = 1'b0;
    end
  end

  assign kcount_inc = kcount + 3'd1;

  always_comb begin
    pre_v       = 1'b0;
    pre         = '0;
    main_v      = 1'b0;
    main        = '0;
    use_idle    = 1'b0;
    mode_next   = mode;
    kchars_next = kchars;
    kcount_next = kcount;
    if (end_of_input) begin
      unique case (mode)
        M_STR: begin
          pre_v = 1'b1;
          pre   = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_QUOTE};
        end
        M_ESC: begin
          pre_v = 1'b1;
          pre   = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_EARLY};
        end
        M_MINUS, M_DOT, M_E, M_ESIGN: begin
          pre_v = 1'b1;
          pre   = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_DIGIT};
        end
        M_INT, M_FRAC, M_EXP: begin
          pre_v = 1'b1;
          pre   = '{kind: KIND_NEND, ch: 8'h00, code: ERR_NONE};
        end
        M_WORD: begin
          pre_v = 1'b1;
          if (kw_ok) begin
            pre = '{kind: kw_kind, ch: 8'h00, code: ERR_NONE};
          end else begin
            pre = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_KEYWORD};
          end
        end
        M_IDLE, M_ERR: begin
          pre_v = 1'b0;
        end
        default: begin
          pre_v = 1'b0;
        end
      endcase
      main_v      = 1'b1;
      main        = '{kind: KIND_END, ch: 8'h00, code: ERR_NONE};
      mode_next   = M_IDLE;
      kchars_next = '0;
      kcount_next = '0;
    end else begin
      unique case (mode)
        M_IDLE: begin
          use_idle = 1'b1;
        end
        M_STR: begin
          priority if (in_byte == 8'h22) begin
            main_v    = 1'b1;
            main      = '{kind: KIND_SEND, ch: 8'h00, code: ERR_NONE};
            mode_next = M_IDLE;
          end else if (in_byte == 8'h5C) begin
            mode_next = M_ESC;
          end else begin
            main_v = 1'b1;
            main   = '{kind: KIND_SCHAR, ch: in_byte, code: ERR_NONE};
          end
        end
        M_ESC: begin
          main_v    = 1'b1;
          main      = '{kind: KIND_SCHAR, ch: in_byte, code: ERR_NONE};
          mode_next = M_STR;
        end
        M_MINUS, M_DOT, M_ESIGN: begin
          main_v = 1'b1;
          if (is_digit(in_byte)) begin
            main      = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
            mode_next = (mode == M_MINUS) ? M_INT : (mode == M_DOT) ? M_FRAC : M_EXP;
          end else begin
            main      = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_DIGIT};
            mode_next = M_ERR;
          end
        end
        M_E: begin
          main_v = 1'b1;
          priority if (in_byte == 8'h2B || in_byte == 8'h2D) begin
            main      = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
            mode_next = M_ESIGN;
          end else if (is_digit(in_byte)) begin
            main      = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
            mode_next = M_EXP;
          end else begin
            main      = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_DIGIT};
            mode_next = M_ERR;
          end
        end
        M_INT, M_FRAC: begin
          priority if (is_digit(in_byte)) begin
            main_v = 1'b1;
            main   = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
          end else if (in_byte == 8'h2E && mode == M_INT) begin
            main_v    = 1'b1;
            main      = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
            mode_next = M_DOT;
          end else if (in_byte == 8'h65 || in_byte == 8'h45) begin
            main_v    = 1'b1;
            main      = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
            mode_next = M_E;
          end else begin
            pre_v    = 1'b1;
            pre      = '{kind: KIND_NEND, ch: 8'h00, code: ERR_NONE};
            use_idle = 1'b1;
          end
        end
        M_EXP: begin
          if (is_digit(in_byte)) begin
            main_v = 1'b1;
            main   = '{kind: KIND_NCHAR, ch: in_byte, code: ERR_NONE};
          end else begin
            pre_v    = 1'b1;
            pre      = '{kind: KIND_NEND, ch: 8'h00, code: ERR_NONE};
            use_idle = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(in_byte)) begin
            for (int i = 0; i < WORD_STORE; i++) begin
              if (kcount == 3'(i)) kchars_next[8*i +: 8] = in_byte;
            end
            kcount_next = kcount_inc;
            if (kcount_inc >= WORD_LIMIT) begin
              kchars_next = '0;
              kcount_next = '0;
              main_v      = 1'b1;
              main        = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_KEYWORD};
              mode_next   = M_ERR;
            end
          end else begin
            kchars_next = '0;
            kcount_next = '0;
            if (kw_ok) begin
              pre_v    = 1'b1;
              pre      = '{kind: kw_kind, ch: 8'h00, code: ERR_NONE};
              use_idle = 1'b1;
            end else begin
              main_v    = 1'b1;
              main      = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_KEYWORD};
              mode_next = M_ERR;
            end
          end
        end
        M_ERR: begin
          mode_next = M_ERR;
        end
        default: begin
          mode_next = M_IDLE;
        end
      endcase
      if (use_idle) begin
        main_v    = id_v;
        main      = id_res;
        mode_next = id_mode;
        if (id_load) begin
          kchars_next = {32'h0, in_byte};
          kcount_next = 3'd1;
        end
      end
    end
  end

  assign entry_valid = pre_v || main_v;
  assign entry.two   = pre_v && main_v;
  assign entry.r0    = pre_v ? pre : main;
  assign entry.r1    = main;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      kchars <= '0;
      kcount <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      kchars <= kchars_next;
      kcount <= kcount_next;
    end
  end

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> mode == M_IDLE && kcount == 3'd0)
    else $error("end of input did not return lexer to idle");

  a_word_count: assert property (@(posedge clk) disable iff (rst)
    kcount < WORD_LIMIT && (kcount == 3'd0 || mode == M_WORD))
    else $error("letter count out of range or outside word");

endmodule

// ===== hdl/jtsl_queue.sv =====
module jtsl_queue import jtsl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[head];

  always_ff @(posedge clk) begin
    if (do_push) slots[tail] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= (tail == LAST_PTR) ? '0 : tail + PW'(1);
      if (do_pop) head <= (head == LAST_PTR) ? '0 : head + PW'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count exceeds depth");

endmodule

// ===== hdl/jtsl_back.sv =====
module jtsl_back import jtsl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       head_empty,
  output logic       head_pop,
  input  logic       pop,
  output logic       empty,
  output logic [3:0] token_kind,
  output logic [7:0] char_value,
  output logic [2:0] error_code,
  output logic       last
);

  logic    second;
  result_t cur;
  logic    xfer;

  assign empty      = head_empty;
  assign cur        = second ? head.r1 : head.r0;
  assign token_kind = cur.kind;
  assign char_value = cur.ch;
  assign error_code = cur.code;
  assign last       = !head.two || second;
  assign xfer       = pop && !head_empty;
  assign head_pop   = xfer && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (xfer) begin
      second <= !last;
    end
  end

  a_second_has_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> !head_empty && head.two)
    else $error("second result selected without a pending pair");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    xfer && !last |=> second && !head_empty)
    else $error("second half of pair lost");

endmodule

// ===== hdl/json_token_stream_lexer_top.sv =====
// JSON token lexer. One byte of JSON text (or an end-of-input marker) is
// taken per push; each yields zero, one or two token results, popped one per
// cycle, with last set on the final result of that byte. A byte is accepted
// every cycle while the result queue (QUEUE_DEPTH entries, one entry per byte
// that yields results) has room; a byte that yields two results takes two
// pops on the output side, so sustained input rate is one byte per cycle
// when the reader pops every cycle and bytes yield at most one result each.
// Errors hold until end of input, which always returns the lexer to idle.
module json_token_stream_lexer_top import jtsl_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] token_kind,
  output logic [7:0] char_value,
  output logic [2:0] error_code,
  output logic       last
);

  logic   accept;
  logic   entry_valid;
  entry_t entry;
  entry_t head;
  logic   head_empty;
  logic   head_pop;

  assign accept = push && !full;

  jtsl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .entry_valid  (entry_valid),
    .entry        (entry)
  );

  jtsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept && entry_valid),
    .wdata (entry),
    .full  (full),
    .pop   (head_pop),
    .rdata (head),
    .empty (head_empty)
  );

  jtsl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .token_kind (token_kind),
    .char_value (char_value),
    .error_code (error_code),
    .last       (last)
  );

endmodule
